// ===== hw/rtl/swsr_pkg.sv =====
// Package for the single-wire sensor reader: item structs, configuration
// struct, register indexes, reset values and result codes.
// Depends on nothing; every other RTL file refers to it by scoped names.
`default_nettype none

package swsr_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned TickW       = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStartLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFirstChk   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSecondChk  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBitSample  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBytesFrame = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [TickW-1:0] RstStartLow   = 16'd18000;
  localparam logic [TickW-1:0] RstStartHigh  = 16'd20;
  localparam logic [TickW-1:0] RstFirstChk   = 16'd40;
  localparam logic [TickW-1:0] RstSecondChk  = 16'd80;
  localparam logic [TickW-1:0] RstBitSample  = 16'd40;
  localparam logic [3:0]       RstBytesFrame = 4'd5;

  // Input operation codes.
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Line drive codes.
  localparam logic [1:0] DriveRelease = 2'd0;
  localparam logic [1:0] DriveLow     = 2'd1;
  localparam logic [1:0] DriveHigh    = 2'd2;

  // Response codes.
  localparam logic [1:0] RespNone   = 2'd0;
  localparam logic [1:0] RespOk     = 2'd1;
  localparam logic [1:0] RespFailed = 2'd2;

  typedef struct packed {
    logic op;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] drive_mode;
    logic       response_valid;
    logic [1:0] response_code;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_last;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0] start_low_ticks;
    logic [TickW-1:0] start_high_ticks;
    logic [TickW-1:0] first_check_ticks;
    logic [TickW-1:0] second_check_ticks;
    logic [TickW-1:0] bit_sample_ticks;
    logic [3:0]       bytes_per_frame;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swsr_cfg_regs.sv =====
// Configuration register file of the single-wire sensor reader.
// Depends on swsr_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module swsr_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output swsr_pkg::cfg_t                       cfg_o
);

  swsr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks    <= swsr_pkg::RstStartLow;
      cfg_q.start_high_ticks   <= swsr_pkg::RstStartHigh;
      cfg_q.first_check_ticks  <= swsr_pkg::RstFirstChk;
      cfg_q.second_check_ticks <= swsr_pkg::RstSecondChk;
      cfg_q.bit_sample_ticks   <= swsr_pkg::RstBitSample;
      cfg_q.bytes_per_frame    <= swsr_pkg::RstBytesFrame;
    end else if (cfg_we_i) begin
      // Writes to indexes beyond the list are dropped.
      unique case (cfg_idx_i)
        swsr_pkg::RegStartLow:   cfg_q.start_low_ticks    <= cfg_wdata_i;
        swsr_pkg::RegStartHigh:  cfg_q.start_high_ticks   <= cfg_wdata_i;
        swsr_pkg::RegFirstChk:   cfg_q.first_check_ticks  <= cfg_wdata_i;
        swsr_pkg::RegSecondChk:  cfg_q.second_check_ticks <= cfg_wdata_i;
        swsr_pkg::RegBitSample:  cfg_q.bit_sample_ticks   <= cfg_wdata_i;
        swsr_pkg::RegBytesFrame: cfg_q.bytes_per_frame    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/swsr_core.sv =====
// Exchange sequencer of the single-wire sensor reader: phase, tick counter,
// bit and byte counters, and the result of one step.
// Depends on swsr_pkg for the item structs, cfg_t and the codes.
`default_nettype none

module swsr_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire swsr_pkg::in_item_t   item_i,
  input  wire swsr_pkg::cfg_t       cfg_i,
  output swsr_pkg::out_item_t       result_o
);

  localparam logic [3:0] PhIdle      = 4'd0;
  localparam logic [3:0] PhStartLow  = 4'd1;
  localparam logic [3:0] PhStartHigh = 4'd2;
  localparam logic [3:0] PhRespOne   = 4'd3;
  localparam logic [3:0] PhRespTwo   = 4'd4;
  localparam logic [3:0] PhRespLow   = 4'd5;
  localparam logic [3:0] PhBitHigh   = 4'd6;
  localparam logic [3:0] PhBitDelay  = 4'd7;
  localparam logic [3:0] PhBitLow    = 4'd8;

  localparam logic [2:0] LastBit = 3'(swsr_pkg::BitsPerByte - 1);

  logic [3:0]                   phase_q, phase_d;
  logic [swsr_pkg::TickW-1:0]   tick_q, tick_d;
  logic [2:0]                   bit_q, bit_d;
  logic [7:0]                   shift_q, shift_d;
  logic [3:0]                   byte_q, byte_d;

  logic [swsr_pkg::TickW-1:0]   tick_inc;
  logic [swsr_pkg::TickW-1:0]   cnt_limit;
  logic                         cnt_done;
  logic [2:0]                   bit_pos;
  logic [4:0]                   byte_inc;
  swsr_pkg::out_item_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      byte_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      byte_q  <= byte_d;
    end
  end

  // One shared wait counter; the limit follows the phase. A zero limit
  // ends the wait after one tick.
  always_comb begin
    unique case (phase_q)
      PhStartLow:  cnt_limit = cfg_i.start_low_ticks;
      PhStartHigh: cnt_limit = cfg_i.start_high_ticks;
      PhRespOne:   cnt_limit = cfg_i.first_check_ticks;
      PhRespTwo:   cnt_limit = cfg_i.second_check_ticks;
      default:     cnt_limit = cfg_i.bit_sample_ticks;
    endcase
  end

  assign tick_inc = tick_q + 16'd1;
  assign cnt_done = (tick_inc >= cnt_limit) || (cnt_limit == '0);
  assign bit_pos  = LastBit - bit_q;
  assign byte_inc = {1'b0, byte_q} + 5'd1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    byte_d  = byte_q;
    res     = '0;

    if (item_i.op == swsr_pkg::OpStart) begin
      // A start while busy is ignored and is not a tick.
      if (phase_q == PhIdle) begin
        phase_d = PhStartLow;
        tick_d  = '0;
        bit_d   = '0;
        shift_d = '0;
        byte_d  = '0;
      end
    end else begin
      unique case (phase_q)
        PhIdle: ;
        PhStartLow: begin
          tick_d = cnt_done ? '0 : tick_inc;
          if (cnt_done) phase_d = PhStartHigh;
        end
        PhStartHigh: begin
          tick_d = cnt_done ? '0 : tick_inc;
          if (cnt_done) phase_d = PhRespOne;
        end
        PhRespOne: begin
          tick_d = cnt_done ? '0 : tick_inc;
          if (cnt_done) begin
            if (item_i.line_level) begin
              res.response_valid = 1'b1;
              res.response_code  = swsr_pkg::RespNone;
              phase_d            = PhIdle;
            end else begin
              phase_d = PhRespTwo;
            end
          end
        end
        PhRespTwo: begin
          tick_d = cnt_done ? '0 : tick_inc;
          if (cnt_done) begin
            res.response_valid = 1'b1;
            if (item_i.line_level) begin
              res.response_code = swsr_pkg::RespOk;
              phase_d           = PhRespLow;
            end else begin
              res.response_code = swsr_pkg::RespFailed;
              phase_d           = PhIdle;
            end
          end
        end
        PhRespLow: begin
          if (!item_i.line_level) phase_d = PhBitHigh;
        end
        PhBitHigh: begin
          if (item_i.line_level) begin
            tick_d  = '0;
            phase_d = PhBitDelay;
          end
        end
        PhBitDelay: begin
          tick_d = cnt_done ? '0 : tick_inc;
          if (cnt_done) begin
            shift_d[bit_pos] = item_i.line_level;
            phase_d          = PhBitLow;
          end
        end
        PhBitLow: begin
          if (!item_i.line_level) begin
            if (bit_q == LastBit) begin
              res.byte_valid = 1'b1;
              res.data_byte  = shift_q;
              // A zero byte count compares as always reached, i.e. one byte.
              if (byte_inc >= {1'b0, cfg_i.bytes_per_frame}) begin
                res.frame_last = 1'b1;
                phase_d        = PhIdle;
              end else begin
                phase_d = PhBitHigh;
              end
              byte_d = byte_inc[3:0];
              bit_d  = '0;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhBitHigh;
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
    end

    // Drive and busy reflect the phase after this step.
    unique case (phase_d)
      PhStartLow:  res.drive_mode = swsr_pkg::DriveLow;
      PhStartHigh: res.drive_mode = swsr_pkg::DriveHigh;
      default:     res.drive_mode = swsr_pkg::DriveRelease;
    endcase
    res.busy_res = (phase_d != PhIdle);
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== hw/rtl/single_wire_sensor_reader_unit.sv =====
// Top level of the single-wire sensor reader: input register, result
// register and the instances of swsr_cfg_regs and swsr_core.
// Depends on swsr_pkg, swsr_cfg_regs and swsr_core.
`default_nettype none

// Host side of a single-wire temperature and humidity sensor exchange. Each
// input item is either one microsecond tick or a start event, and each item
// gives exactly one result item: the line drive after the step, a response
// report when the response check ends, a data byte when one completes, and
// the busy flag. An accepted item first lands in an input register; when the
// output register has room, the sequencer evaluates it against the current
// phase and counters and the result is captured in the output register. Both
// registers advance together whenever the output register is empty or being
// drained, so while that holds a new item is taken in every cycle: throughput
// is one item per clock. Each item is registered in the input register, and its
// result then in the output register. The rate is set by the single step of the
// phase sequencer, whose state feeds back into the next item. Configuration
// writes on the plain write port take effect at the next clock edge and are
// meant to be issued while the block is idle.

module single_wire_sensor_reader_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire swsr_pkg::in_item_t              in_item_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output swsr_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  swsr_pkg::cfg_t      cfg;
  swsr_pkg::in_item_t  inq_q;
  logic                inq_valid_q;
  swsr_pkg::out_item_t out_q;
  logic                out_valid_q;
  swsr_pkg::out_item_t step_res;
  logic                advance;
  logic                in_fire;

  // The held item moves on when the result register has room.
  assign advance    = inq_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_fire) begin
      inq_valid_q <= 1'b1;
    end else if (advance) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  swsr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  swsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (inq_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

`ifndef SYNTH
  // A step never reports a response and a byte at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.response_valid && out_q.byte_valid))
    else $error("response and byte reported in one item");

  // The line is only driven while an exchange is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.drive_mode != swsr_pkg::DriveRelease)) |-> out_q.busy_res)
    else $error("line driven while idle");

  // The last byte of a frame ends the exchange.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_last) |-> (out_q.byte_valid && !out_q.busy_res))
    else $error("frame end without byte or with busy");

  // A held item with a stalled result register blocks new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inq_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline is full");

  // A result register that was stalled still holds its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(out_valid_q) && !$past(out_ready_i)) |-> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for single_wire_sensor_reader_unit: it plays the sensor side of
// the exchange, predicts every result item of the reader and checks them in order.
// Depends on swsr_pkg and the RTL of single_wire_sensor_reader_unit.
`timescale 1ns / 1ps

module testbench;

  // Generous ceiling on the run. The run needs a few thousand items; even a last random
  // round with the largest frames under the slowest sender and receiver stays far below.
  localparam int unsigned CycleLimit = 1000000;

  // Indexes past the last register. Writes to them must change nothing.
  localparam logic [swsr_pkg::CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [swsr_pkg::CfgIdxW-1:0] RegSpareB = 3'd7;

  // Phases of the exchange sequencer as the predictor tracks them.
  typedef enum logic [3:0] {
    PhIdle, PhStartLow, PhStartHigh, PhRespOne, PhRespTwo,
    PhRespLow, PhBitHigh, PhBitDelay, PhBitLow
  } seq_phase_e;

  // Modes of the result receiver's ready pattern.
  typedef enum logic [1:0] {RxOpen, RxSparse, RxRhythm, RxCoin} rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  swsr_pkg::in_item_t            in_item   = '0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  swsr_pkg::out_item_t           out_item;
  logic                          cfg_we    = 1'b0;
  logic [swsr_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [swsr_pkg::CfgDataW-1:0] cfg_wdata = '0;

  single_wire_sensor_reader_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the registers and of the sequencer state and
  // advances them by one step for every item the reader accepts.
  // ---------------------------------------------------------------------------------------
  swsr_pkg::cfg_t reader_cfg;
  seq_phase_e     seq_phase;
  logic [15:0]    wait_count;
  logic [2:0]     bit_pos;
  logic [7:0]     byte_shift;
  logic [3:0]     bytes_done;

  function automatic void reset_reader();
    reader_cfg.start_low_ticks    = swsr_pkg::RstStartLow;
    reader_cfg.start_high_ticks   = swsr_pkg::RstStartHigh;
    reader_cfg.first_check_ticks  = swsr_pkg::RstFirstChk;
    reader_cfg.second_check_ticks = swsr_pkg::RstSecondChk;
    reader_cfg.bit_sample_ticks   = swsr_pkg::RstBitSample;
    reader_cfg.bytes_per_frame    = swsr_pkg::RstBytesFrame;
    seq_phase  = PhIdle;
    wait_count = '0;
    bit_pos    = '0;
    byte_shift = '0;
    bytes_done = '0;
  endfunction

  // One tick of a timed wait. A register value of zero ends the wait on the first tick,
  // just as a value of one does.
  function automatic logic wait_elapsed(logic [15:0] span);
    wait_count = wait_count + 16'd1;
    if (wait_count >= span || span == 16'd0) begin
      wait_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic swsr_pkg::out_item_t step_reader(swsr_pkg::in_item_t item);
    swsr_pkg::out_item_t res;
    res = '0;
    if (item.op == swsr_pkg::OpStart) begin
      // A start only counts while idle; during an exchange it is dropped without a tick.
      if (seq_phase == PhIdle) begin
        seq_phase  = PhStartLow;
        wait_count = '0;
        bit_pos    = '0;
        byte_shift = '0;
        bytes_done = '0;
      end
    end else begin
      case (seq_phase)
        PhStartLow: begin
          if (wait_elapsed(reader_cfg.start_low_ticks)) seq_phase = PhStartHigh;
        end
        PhStartHigh: begin
          if (wait_elapsed(reader_cfg.start_high_ticks)) seq_phase = PhRespOne;
        end
        PhRespOne: begin
          if (wait_elapsed(reader_cfg.first_check_ticks)) begin
            if (item.line_level) begin
              // The sensor never pulled the line low: no response at all.
              res.response_valid = 1'b1;
              res.response_code  = swsr_pkg::RespNone;
              seq_phase = PhIdle;
            end else begin
              seq_phase = PhRespTwo;
            end
          end
        end
        PhRespTwo: begin
          if (wait_elapsed(reader_cfg.second_check_ticks)) begin
            res.response_valid = 1'b1;
            if (item.line_level) begin
              res.response_code = swsr_pkg::RespOk;
              seq_phase = PhRespLow;
            end else begin
              res.response_code = swsr_pkg::RespFailed;
              seq_phase = PhIdle;
            end
          end
        end
        PhRespLow: begin
          if (!item.line_level) seq_phase = PhBitHigh;
        end
        PhBitHigh: begin
          if (item.line_level) begin
            wait_count = '0;
            seq_phase  = PhBitDelay;
          end
        end
        PhBitDelay: begin
          if (wait_elapsed(reader_cfg.bit_sample_ticks)) begin
            byte_shift[3'd7 - bit_pos] = item.line_level;
            seq_phase = PhBitLow;
          end
        end
        PhBitLow: begin
          if (!item.line_level) begin
            if (bit_pos == 3'd7) begin
              res.byte_valid = 1'b1;
              res.data_byte  = byte_shift;
              if ({1'b0, bytes_done} + 5'd1 >= {1'b0, reader_cfg.bytes_per_frame}) begin
                res.frame_last = 1'b1;
                seq_phase = PhIdle;
              end else begin
                seq_phase = PhBitHigh;
              end
              bytes_done = bytes_done + 4'd1;
              bit_pos    = '0;
            end else begin
              bit_pos   = bit_pos + 3'd1;
              seq_phase = PhBitHigh;
            end
          end
        end
        default: seq_phase = PhIdle;
      endcase
    end
    res.drive_mode = (seq_phase == PhStartLow)  ? swsr_pkg::DriveLow :
                     (seq_phase == PhStartHigh) ? swsr_pkg::DriveHigh :
                                                  swsr_pkg::DriveRelease;
    res.busy_res   = (seq_phase != PhIdle);
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Bookkeeping shared by the processes below.
  // ---------------------------------------------------------------------------------------
  swsr_pkg::in_item_t  line_items[$];   // items waiting to be offered to the reader
  swsr_pkg::out_item_t due_results[$];  // predicted results not yet seen at the output
  int unsigned queued_count = 0;  // items ever put into line_items
  int unsigned taken_count  = 0;  // items the reader has accepted
  int unsigned results_seen = 0;
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  logic        in_taken     = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts the valid drops for a
  // random gap. Long bursts give stretches without any idling. A new item is only put on
  // the bus once the previous one was taken at the last rising edge.
  // ---------------------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (line_items.size() != 0) begin
        in_item  <= line_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(1, 24);
          gap_left   = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver. It switches between an open mode, sparse stalls, a fixed rhythm and coin
  // flips. Once, after 200 results, it holds ready low while the sender keeps offering,
  // so the reader's registers fill and its input stalls.
  // ---------------------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RxOpen;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_beat   = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    rx_beat++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 200) begin
      hold_done = 1'b1;
      hold_left = 299;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RxOpen:   out_ready <= 1'b1;
        RxSparse: out_ready <= ($urandom_range(0, 3) != 0);
        RxRhythm: out_ready <= ((rx_beat % 7) >= 3);
        default:  out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge: an accepted item is run through the
  // predictor, and an accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    swsr_pkg::out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        due_results.push_back(step_reader(in_item));
        taken_count++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d arrived with no item to account for it", results_seen);
        end else begin
          want = due_results.pop_front();
          if (out_item.drive_mode !== want.drive_mode ||
              out_item.response_valid !== want.response_valid ||
              out_item.response_code !== want.response_code ||
              out_item.byte_valid !== want.byte_valid ||
              out_item.data_byte !== want.data_byte ||
              out_item.frame_last !== want.frame_last ||
              out_item.busy_res !== want.busy_res) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("result %0d mismatch (exp/got): drive %0d/%0d rsp_v %0d/%0d rsp %0d/%0d",
                       results_seen, want.drive_mode, out_item.drive_mode,
                       want.response_valid, out_item.response_valid,
                       want.response_code, out_item.response_code);
              $display("  byte_v %0d/%0d byte %h/%h last %0d/%0d busy %0d/%0d",
                       want.byte_valid, out_item.byte_valid,
                       want.data_byte, out_item.data_byte,
                       want.frame_last, out_item.frame_last,
                       want.busy_res, out_item.busy_res);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. They model the sensor: they know the register settings and shape the
  // line so that each wait ends on the intended level.
  // ---------------------------------------------------------------------------------------
  task automatic push_item(input logic op, input logic level);
    swsr_pkg::in_item_t item;
    item.op         = op;
    item.line_level = level;
    line_items.push_back(item);
    queued_count++;
  endtask

  // A stray start during an exchange. The reader must drop it and spend no tick on it.
  task automatic maybe_stray_start();
    if ($urandom_range(0, 39) == 0) push_item(swsr_pkg::OpStart, 1'($urandom_range(0, 1)));
  endtask

  // A timed wait of the given length: random line noise, then the tick that ends the wait
  // carries the level that the reader samples.
  task automatic timed_wait(input logic [15:0] span, input logic sample_level);
    int unsigned ticks;
    ticks = (span == 16'd0) ? 1 : span;
    for (int unsigned k = 1; k < ticks; k++) begin
      maybe_stray_start();
      push_item(swsr_pkg::OpTick, 1'($urandom_range(0, 1)));
    end
    maybe_stray_start();
    push_item(swsr_pkg::OpTick, sample_level);
  endtask

  // Ticks that hold the line at a level the reader is not waiting for.
  task automatic hold_level(input logic level, input int unsigned most);
    repeat ($urandom_range(0, most)) begin
      maybe_stray_start();
      push_item(swsr_pkg::OpTick, level);
    end
  endtask

  // One full exchange from the start event to the response, and for a good response the
  // whole frame of data bytes.
  task automatic queue_exchange(input logic [1:0] outcome);
    int unsigned frame_bytes;
    logic [7:0]  value;
    push_item(swsr_pkg::OpStart, 1'($urandom_range(0, 1)));
    timed_wait(reader_cfg.start_low_ticks, 1'($urandom_range(0, 1)));
    timed_wait(reader_cfg.start_high_ticks, 1'($urandom_range(0, 1)));
    timed_wait(reader_cfg.first_check_ticks, outcome == swsr_pkg::RespNone);
    if (outcome != swsr_pkg::RespNone) begin
      timed_wait(reader_cfg.second_check_ticks, outcome == swsr_pkg::RespOk);
      if (outcome == swsr_pkg::RespOk) begin
        // The sensor's high response phase, then the falling edge before the first bit.
        hold_level(1'b1, 3);
        push_item(swsr_pkg::OpTick, 1'b0);
        frame_bytes = (reader_cfg.bytes_per_frame == 4'd0) ? 1 : reader_cfg.bytes_per_frame;
        repeat (frame_bytes) begin
          value = ($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
                                              : 8'($urandom_range(0, 255));
          for (int j = 7; j >= 0; j--) begin
            hold_level(1'b0, 2);
            push_item(swsr_pkg::OpTick, 1'b1);
            timed_wait(reader_cfg.bit_sample_ticks, value[j]);
            hold_level(1'b1, 2);
            push_item(swsr_pkg::OpTick, 1'b0);
          end
        end
      end
    end
  endtask

  task automatic write_reg(input logic [swsr_pkg::CfgIdxW-1:0] idx,
                           input logic [swsr_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      swsr_pkg::RegStartLow:   reader_cfg.start_low_ticks    = value;
      swsr_pkg::RegStartHigh:  reader_cfg.start_high_ticks   = value;
      swsr_pkg::RegFirstChk:   reader_cfg.first_check_ticks  = value;
      swsr_pkg::RegSecondChk:  reader_cfg.second_check_ticks = value;
      swsr_pkg::RegBitSample:  reader_cfg.bit_sample_ticks   = value;
      swsr_pkg::RegBytesFrame: reader_cfg.bytes_per_frame    = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item was accepted and every result has come back, then wait
  // on so that the two-stage pipeline can show any stray result.
  task automatic settle();
    do @(negedge clk_i);
    while (taken_count != queued_count || due_results.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [15:0] short_span();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 16'd0;
    if (pick < 12) return 16'($urandom_range(1, 6));
    return 16'($urandom_range(7, 40));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    logic [3:0]  frame_bytes;

    reset_reader();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the start high time and both response checks. Only the start pulse
    // is shortened; the exchange ends in a failed response.
    write_reg(swsr_pkg::RegStartLow, 16'd3);
    push_item(swsr_pkg::OpTick, 1'b1);
    queue_exchange(swsr_pkg::RespFailed);
    settle();

    // A full frame at the reset byte count, with quick checks and bit samples.
    write_reg(swsr_pkg::RegStartHigh, 16'd2);
    write_reg(swsr_pkg::RegFirstChk, 16'd2);
    write_reg(swsr_pkg::RegSecondChk, 16'd2);
    write_reg(swsr_pkg::RegBitSample, 16'd1);
    queue_exchange(swsr_pkg::RespOk);
    settle();

    // Directed part with the shortest timing. Idle ticks at both levels, a start and a
    // repeated start that end in no response, a start that ends in a failed response, then
    // one good exchange. The spare indexes are written too and must not disturb anything.
    write_reg(swsr_pkg::RegStartLow, 16'd1);
    write_reg(swsr_pkg::RegStartHigh, 16'd1);
    write_reg(swsr_pkg::RegFirstChk, 16'd1);
    write_reg(swsr_pkg::RegSecondChk, 16'd1);
    write_reg(swsr_pkg::RegBitSample, 16'd1);
    write_reg(swsr_pkg::RegBytesFrame, 16'd1);
    write_reg(RegSpareA, 16'($urandom));
    write_reg(RegSpareB, 16'($urandom));
    push_item(swsr_pkg::OpTick, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b1);
    push_item(swsr_pkg::OpStart, 1'b1);
    push_item(swsr_pkg::OpStart, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b1);
    push_item(swsr_pkg::OpTick, 1'b1);
    push_item(swsr_pkg::OpStart, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b1);
    push_item(swsr_pkg::OpTick, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b0);
    push_item(swsr_pkg::OpTick, 1'b0);
    queue_exchange(swsr_pkg::RespOk);
    settle();

    // Zero wait registers, with a silent sensor.
    write_reg(swsr_pkg::RegStartLow, 16'd0);
    write_reg(swsr_pkg::RegStartHigh, 16'd0);
    write_reg(swsr_pkg::RegFirstChk, 16'd0);
    queue_exchange(swsr_pkg::RespNone);
    settle();

    // A byte count of zero must act as one byte.
    write_reg(swsr_pkg::RegSecondChk, 16'd0);
    write_reg(swsr_pkg::RegBitSample, 16'd0);
    write_reg(swsr_pkg::RegBytesFrame, 16'd0);
    queue_exchange(swsr_pkg::RespOk);
    settle();

    // The largest byte count the register holds.
    write_reg(swsr_pkg::RegBitSample, 16'd1);
    write_reg(swsr_pkg::RegBytesFrame, 16'hFFFF);
    queue_exchange(swsr_pkg::RespOk);
    settle();

    // Random part: fresh short settings for each round, a few exchanges per round with
    // idle noise in between. Most exchanges succeed so the data path sees real traffic.
    while (queued_count < 1600) begin
      write_reg(swsr_pkg::RegStartLow, short_span());
      write_reg(swsr_pkg::RegStartHigh, short_span());
      write_reg(swsr_pkg::RegFirstChk, short_span());
      write_reg(swsr_pkg::RegSecondChk, short_span());
      write_reg(swsr_pkg::RegBitSample, short_span());
      frame_bytes = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 5))
                                                : 4'($urandom_range(0, 15));
      write_reg(swsr_pkg::RegBytesFrame, {12'($urandom), frame_bytes});
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 3)) push_item(swsr_pkg::OpTick, 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        queue_exchange((pick < 7) ? swsr_pkg::RespOk :
                       (pick < 8) ? swsr_pkg::RespFailed : swsr_pkg::RespNone);
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
